### rtl/brle_pkg.sv
// Shared constants, status codes and queue entry type for the byte run-length encoder.
package brle_pkg;

    localparam int MAX_LEN_DEF     = 65535;
    localparam int MAX_RUN_DEF     = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [17:0] CAP_RESET     = 18'd131072;
    localparam logic [16:0] WRITTEN_LIMIT = 17'd131070;
    localparam logic [17:0] PAIR_BYTES    = 18'd2;
    localparam logic [17:0] TWO_PAIR_BYTES = 18'd4;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_CAP_EXCEEDED = 2'd1,
        ST_NOT_SMALLER  = 2'd2,
        ST_TOO_LONG     = 2'd3
    } status_t;

    // One accepted byte's work: an optional closed-run pair and an optional final result.
    typedef struct packed {
        logic        has_pair;
        logic [7:0]  pair_value;
        logic [7:0]  pair_cnt;
        logic        has_final;
        logic        final_valid;
        logic [7:0]  final_value;
        logic [7:0]  final_cnt;
        logic        too_long;
        logic        overflow;
        logic [16:0] written;
        logic [16:0] read;
    } job_t;

    // Queue state seen by its neighbors.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

### rtl/brle_front.sv
// Front end: run tracking, byte counters, capacity check and job generation.
module brle_front #(
    parameter int MAX_LEN = brle_pkg::MAX_LEN_DEF,
    parameter int MAX_RUN = brle_pkg::MAX_RUN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [17:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  brle_pkg::q_stat_t  q_stat,
    output logic               push,
    output brle_pkg::job_t     job
);
    import brle_pkg::*;

    localparam logic [16:0] MaxLenW = 17'(MAX_LEN);
    localparam logic [8:0]  MaxRunW = 9'(MAX_RUN);

    logic [17:0] cap_reg;
    logic [7:0]  rv_reg, rv_next;
    logic [8:0]  rl_reg, rl_next;
    logic [16:0] bw_reg, bw_next;
    logic [16:0] br_reg, br_next;
    logic        ovf_reg, ovf_next;
    logic        tl_reg, tl_next;

    logic        accept;
    logic        close;
    logic [16:0] cap17;
    logic        fit2, fit4, fit_final;
    logic        ok1, ok2, ovf1;
    logic [7:0]  rv_new;
    logic [8:0]  rl_new;
    logic [16:0] bw_new, br_new;
    logic        tl_new;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cap17 = (cap_reg > {1'b0, WRITTEN_LIMIT}) ? WRITTEN_LIMIT : cap_reg[16:0];
        fit2  = ({1'b0, bw_reg} + PAIR_BYTES) <= {1'b0, cap17};
        fit4  = ({1'b0, bw_reg} + TWO_PAIR_BYTES) <= {1'b0, cap17};

        if (br_reg < MaxLenW)
        begin
            br_new = br_reg + 17'd1;
            tl_new = tl_reg;
        end
        else
        begin
            br_new = br_reg;
            tl_new = 1'b1;
        end

        close = (rl_reg != 9'd0) && ((in_byte != rv_reg) || (rl_reg >= MaxRunW));
        ok1   = close && !ovf_reg && fit2;
        ovf1  = ovf_reg || (close && !fit2);

        if (close || rl_reg == 9'd0)
        begin
            rv_new = in_byte;
            rl_new = 9'd1;
        end
        else
        begin
            rv_new = rv_reg;
            rl_new = rl_reg + 9'd1;
        end

        // second pair on this byte needs room for both
        fit_final = ok1 ? fit4 : fit2;
        ok2       = in_last && !ovf1 && fit_final;

        case ({ok1, ok2})
            2'b11:   bw_new = bw_reg + 17'd4;
            2'b10,
            2'b01:   bw_new = bw_reg + 17'd2;
            default: bw_new = bw_reg;
        endcase

        job.has_pair    = ok1;
        job.pair_value  = rv_reg;
        job.pair_cnt    = 8'(rl_reg - 9'd1);
        job.has_final   = in_last;
        job.final_valid = ok2;
        job.final_value = rv_new;
        job.final_cnt   = 8'(rl_new - 9'd1);
        job.too_long    = tl_new;
        job.overflow    = ovf1 || (in_last && !ovf1 && !fit_final);
        job.written     = bw_new;
        job.read        = br_new;

        push = accept && (ok1 || in_last);

        rv_next  = rv_reg;
        rl_next  = rl_reg;
        bw_next  = bw_reg;
        br_next  = br_reg;
        ovf_next = ovf_reg;
        tl_next  = tl_reg;
        if (accept)
        begin
            if (in_last)
            begin
                rv_next  = 8'd0;
                rl_next  = 9'd0;
                bw_next  = 17'd0;
                br_next  = 17'd0;
                ovf_next = 1'b0;
                tl_next  = 1'b0;
            end
            else
            begin
                rv_next  = rv_new;
                rl_next  = rl_new;
                bw_next  = bw_new;
                br_next  = br_new;
                ovf_next = ovf1;
                tl_next  = tl_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            rv_reg  <= 8'd0;
            rl_reg  <= 9'd0;
            bw_reg  <= 17'd0;
            br_reg  <= 17'd0;
            ovf_reg <= 1'b0;
            tl_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            rv_reg  <= rv_next;
            rl_reg  <= rl_next;
            bw_reg  <= bw_next;
            br_reg  <= br_next;
            ovf_reg <= ovf_next;
            tl_reg  <= tl_next;
        end
    end

endmodule

### rtl/brle_queue.sv
// Short job queue between front and back ends.
module brle_queue #(
    parameter int DEPTH = brle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  brle_pkg::job_t     push_job,
    input  logic               pop,
    output brle_pkg::job_t     head,
    output brle_pkg::q_stat_t  q_stat
);
    import brle_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == FullCnt);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !q_stat.full;
        do_pop      = pop && !q_stat.empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/brle_back.sv
// Back end: splits jobs into results, resolves final status, drives the output register.
module brle_back (
    input  logic               clk,
    input  logic               rst_n,
    input  brle_pkg::job_t     head,
    input  brle_pkg::q_stat_t  q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_value,
    output logic [7:0]         out_cnt,
    output logic               out_pair_valid,
    output logic               out_done,
    output logic [1:0]         out_status,
    output logic [16:0]        out_len
);
    import brle_pkg::*;

    logic        valid_reg, valid_next;
    logic        pair_done_reg, pair_done_next;
    logic [7:0]  value_reg, value_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        pv_reg, pv_next;
    logic        done_reg, done_next;
    status_t     status_reg, status_next;
    logic [16:0] len_reg, len_next;

    logic        load;
    logic        emit_pair;
    status_t     st;

    always_comb
    begin
        load      = !q_stat.empty && (!valid_reg || out_ready);
        emit_pair = head.has_pair && !pair_done_reg;
        pop       = load && (!emit_pair || !head.has_final);

        if (head.too_long)
            st = ST_TOO_LONG;
        else if (head.overflow)
            st = ST_CAP_EXCEEDED;
        else if (head.written >= head.read)
            st = ST_NOT_SMALLER;
        else
            st = ST_OK;

        valid_next     = valid_reg && !out_ready;
        pair_done_next = pair_done_reg;
        value_next     = value_reg;
        cnt_next       = cnt_reg;
        pv_next        = pv_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        len_next       = len_reg;

        if (load)
        begin
            valid_next     = 1'b1;
            pair_done_next = emit_pair && head.has_final;
            if (emit_pair)
            begin
                value_next  = head.pair_value;
                cnt_next    = head.pair_cnt;
                pv_next     = 1'b1;
                done_next   = 1'b0;
                status_next = ST_OK;
                len_next    = 17'd0;
            end
            else
            begin
                value_next  = head.final_valid ? head.final_value : 8'd0;
                cnt_next    = head.final_valid ? head.final_cnt : 8'd0;
                pv_next     = head.final_valid;
                done_next   = 1'b1;
                status_next = st;
                len_next    = (st == ST_OK) ? head.written : 17'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            pair_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            pair_done_reg <= pair_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        cnt_reg    <= cnt_next;
        pv_reg     <= pv_next;
        done_reg   <= done_next;
        status_reg <= status_next;
        len_reg    <= len_next;
    end

    assign out_valid      = valid_reg;
    assign out_value      = value_reg;
    assign out_cnt        = cnt_reg;
    assign out_pair_valid = pv_reg;
    assign out_done       = done_reg;
    assign out_status     = status_reg;
    assign out_len        = len_reg;

endmodule

### rtl/byte_run_length_encoder.sv
// Top level of the byte run-length encoder: front end, job queue and back end.
//
// Usage:
//   s_axis carries the plane one byte per transaction; tlast marks its final byte.
//   m_axis carries results: one per closed run, plus a final result (tlast high)
//   on the plane's last byte that also holds the pair of the last run and a status.
//   cfg_wr_en/cfg_wr_data write output_capacity; write only while the block is idle.
// Path: a result passes the job queue and the output register before it reaches m_axis.
// Throughput: one byte per cycle while the queue has room; the back end drives one
//   result per cycle when m_axis is ready, so a run-closing last byte yields two results.
//   The front end computes all run and count state in the accepting cycle.
// Stall: when m_axis_tready is low, the output register holds its result and the
//   4-entry job queue keeps absorbing bytes; s_axis_tready drops only when the
//   queue is full.
// Reset: rst_n (async, active low) clears the run state, counters, flags and the
//   queue and sets output_capacity to 131072. State also clears after each plane.
module byte_run_length_encoder #(
    parameter int MAX_LEN     = brle_pkg::MAX_LEN_DEF,
    parameter int MAX_RUN     = brle_pkg::MAX_RUN_DEF,
    parameter int QUEUE_DEPTH = brle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [17:0] cfg_wr_data,    // output_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] pair_value, [15:8] pair_count_minus_one,
                                        // [32:16] encoded_length, [39:33] zero
    output logic [2:0]  m_axis_tuser,   // [0] pair_valid, [2:1] status
    output logic        m_axis_tlast    // done_res
);
    import brle_pkg::*;

    job_t    job, head;
    q_stat_t q_stat;
    logic    push, pop;

    logic [7:0]  o_value, o_cnt;
    logic        o_pv, o_done;
    logic [1:0]  o_status;
    logic [16:0] o_len;

    // Front end: classifies each byte, keeps run and counters, builds jobs.
    brle_front #(
        .MAX_LEN (MAX_LEN),
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .q_stat      (q_stat),
        .push        (push),
        .job         (job)
    );

    // Decoupling queue; a job may hold up to two results.
    brle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // Back end: emits pair then final result, resolves status priority.
    brle_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_stat         (q_stat),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_value      (o_value),
        .out_cnt        (o_cnt),
        .out_pair_valid (o_pv),
        .out_done       (o_done),
        .out_status     (o_status),
        .out_len        (o_len)
    );

    assign m_axis_tdata = {7'd0, o_len, o_cnt, o_value};
    assign m_axis_tuser = {o_status, o_pv};
    assign m_axis_tlast = o_done;

endmodule
